// ===== design/vend_pkg.sv =====
package vend_pkg;

   // Fixed widths of the item fields.
   localparam int DATA_W              = 8;
   localparam int MODE_CODE_W         = 4;
   localparam int CSR_INDEX_W         = 1;
   localparam int MONEY_WIDTH_DEFAULT = 8;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_PRICE_FIRST  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRICE_SECOND = 1'd1;

   localparam logic [DATA_W-1:0] PRICE_FIRST_RESET  = 8'd2;
   localparam logic [DATA_W-1:0] PRICE_SECOND_RESET = 8'd1;

   // External mode codes as they appear in the result word.
   localparam logic [MODE_CODE_W-1:0] CODE_IDLE    = 4'd0;
   localparam logic [MODE_CODE_W-1:0] CODE_PAY     = 4'd1;
   localparam logic [MODE_CODE_W-1:0] CODE_SHORT   = 4'd2;
   localparam logic [MODE_CODE_W-1:0] CODE_DROP1   = 4'd3;
   localparam logic [MODE_CODE_W-1:0] CODE_DROP2   = 4'd4;
   localparam logic [MODE_CODE_W-1:0] CODE_REFUND  = 4'd5;
   localparam logic [MODE_CODE_W-1:0] CODE_UNLOCK  = 4'd6;
   localparam logic [MODE_CODE_W-1:0] CODE_COLLECT = 4'd7;
   localparam logic [MODE_CODE_W-1:0] CODE_QUIT    = 4'd8;
   localparam logic [MODE_CODE_W-1:0] CODE_LOCK    = 4'd9;

   typedef enum logic [9:0] {
      MODE_IDLE    = 10'b00_0000_0001,
      MODE_PAY     = 10'b00_0000_0010,
      MODE_SHORT   = 10'b00_0000_0100,
      MODE_DROP1   = 10'b00_0000_1000,
      MODE_DROP2   = 10'b00_0001_0000,
      MODE_REFUND  = 10'b00_0010_0000,
      MODE_UNLOCK  = 10'b00_0100_0000,
      MODE_COLLECT = 10'b00_1000_0000,
      MODE_QUIT    = 10'b01_0000_0000,
      MODE_LOCK    = 10'b10_0000_0000
   } mode_type;

   typedef struct packed {
      logic coin_half;
      logic coin_whole;
      logic pick_first;
      logic pick_second;
      logic cancel_press;
   } vend_in_type;

   typedef struct packed {
      logic [MODE_CODE_W-1:0] next_mode;
      logic                   drop_first;
      logic                   drop_second;
      logic                   door_motor;
      logic                   change_motor;
      logic                   lamp_short;
      logic                   lamp_locked;
      logic                   lamp_unlocked;
      logic                   lamp_collect;
      logic                   lamp_change;
      logic [DATA_W-1:0]      credit_now;
      logic [DATA_W-1:0]      change_now;
   } vend_out_type;

   function automatic logic [MODE_CODE_W-1:0] mode_code(input mode_type m);
      logic [MODE_CODE_W-1:0] c;
      case (m)
         MODE_IDLE:    c = CODE_IDLE;
         MODE_PAY:     c = CODE_PAY;
         MODE_SHORT:   c = CODE_SHORT;
         MODE_DROP1:   c = CODE_DROP1;
         MODE_DROP2:   c = CODE_DROP2;
         MODE_REFUND:  c = CODE_REFUND;
         MODE_UNLOCK:  c = CODE_UNLOCK;
         MODE_COLLECT: c = CODE_COLLECT;
         MODE_QUIT:    c = CODE_QUIT;
         MODE_LOCK:    c = CODE_LOCK;
         default:      c = CODE_IDLE;
      endcase
      return c;
   endfunction

endpackage

// ===== design/vend_step.sv =====
// One pass of the control loop: from the current mode, money and button word
// to the next mode, money and the motor and lamp levels of this pass.
module vend_step #(
   parameter int MONEY_WIDTH = vend_pkg::MONEY_WIDTH_DEFAULT
) (
   input  vend_pkg::mode_type                 mode,
   input  logic [MONEY_WIDTH-1:0]             credit,
   input  logic [MONEY_WIDTH-1:0]             change_due,
   input  logic [vend_pkg::DATA_W-1:0]        price_first,
   input  logic [vend_pkg::DATA_W-1:0]        price_second,
   input  vend_pkg::vend_in_type              buttons,
   output vend_pkg::mode_type                 mode_next,
   output logic [MONEY_WIDTH-1:0]             credit_next,
   output logic [MONEY_WIDTH-1:0]             change_next,
   output vend_pkg::vend_out_type             result
);

   localparam int SUM_W = MONEY_WIDTH + 2;
   localparam int CMP_W = (MONEY_WIDTH > vend_pkg::DATA_W) ? MONEY_WIDTH : vend_pkg::DATA_W;
   localparam int OUT_W = vend_pkg::DATA_W;

   logic [SUM_W-1:0]       sum_raw;
   logic [MONEY_WIDTH-1:0] credit_sat;
   logic [CMP_W-1:0]       credit_cmp;
   logic [CMP_W-1:0]       price1_cmp;
   logic [CMP_W-1:0]       price2_cmp;
   logic [CMP_W-1:0]       rest1;
   logic [CMP_W-1:0]       rest2;
   logic                   afford1;
   logic                   afford2;
   logic [CMP_W-1:0]       credit_out;
   logic [CMP_W-1:0]       change_out;

   // Coins add at most three half units; the sum saturates at full scale.
   assign sum_raw    = SUM_W'(credit) + SUM_W'({buttons.coin_whole, buttons.coin_half});
   assign credit_sat = (|sum_raw[SUM_W-1:MONEY_WIDTH]) ? {MONEY_WIDTH{1'b1}}
                                                       : sum_raw[MONEY_WIDTH-1:0];

   assign credit_cmp = CMP_W'(credit_sat);
   assign price1_cmp = CMP_W'(price_first);
   assign price2_cmp = CMP_W'(price_second);
   assign afford1    = credit_cmp >= price1_cmp;
   assign afford2    = credit_cmp >= price2_cmp;
   assign rest1      = credit_cmp - price1_cmp;
   assign rest2      = credit_cmp - price2_cmp;

   always_comb begin
      mode_next   = vend_pkg::MODE_IDLE;
      credit_next = credit;
      change_next = change_due;
      result      = '0;
      case (mode)
         vend_pkg::MODE_IDLE: begin
            result.lamp_locked = 1'b1;
            credit_next        = credit_sat;
            if (buttons.coin_half || buttons.coin_whole) begin
               mode_next = vend_pkg::MODE_PAY;
            end
         end
         vend_pkg::MODE_PAY: begin
            result.lamp_locked = 1'b1;
            mode_next          = vend_pkg::MODE_PAY;
            credit_next        = credit_sat;
            // Later rules override earlier ones.
            if (buttons.cancel_press) begin
               change_next = credit;
               mode_next   = vend_pkg::MODE_QUIT;
            end
            if (buttons.pick_first && afford1) begin
               change_next = rest1[MONEY_WIDTH-1:0];
               mode_next   = vend_pkg::MODE_DROP1;
            end
            if (buttons.pick_second && afford2) begin
               change_next = rest2[MONEY_WIDTH-1:0];
               mode_next   = vend_pkg::MODE_DROP2;
            end
            if ((buttons.pick_first && !afford1) || (buttons.pick_second && !afford2)) begin
               mode_next = vend_pkg::MODE_SHORT;
            end
            if (mode_next == vend_pkg::MODE_QUIT || mode_next == vend_pkg::MODE_DROP1 ||
                mode_next == vend_pkg::MODE_DROP2) begin
               credit_next = '0;
            end
         end
         vend_pkg::MODE_SHORT: begin
            result.lamp_short  = 1'b1;
            result.lamp_locked = 1'b1;
            mode_next          = vend_pkg::MODE_PAY;
         end
         vend_pkg::MODE_DROP1,
         vend_pkg::MODE_DROP2: begin
            result.drop_first  = (mode == vend_pkg::MODE_DROP1);
            result.drop_second = (mode == vend_pkg::MODE_DROP2);
            result.lamp_locked = 1'b1;
            mode_next = (|change_due) ? vend_pkg::MODE_REFUND : vend_pkg::MODE_UNLOCK;
         end
         vend_pkg::MODE_REFUND: begin
            result.change_motor = 1'b1;
            result.lamp_locked  = 1'b1;
            result.lamp_change  = 1'b1;
            change_next         = '0;
            mode_next           = vend_pkg::MODE_UNLOCK;
         end
         vend_pkg::MODE_UNLOCK: begin
            result.door_motor    = 1'b1;
            result.lamp_unlocked = 1'b1;
            mode_next            = vend_pkg::MODE_COLLECT;
         end
         vend_pkg::MODE_COLLECT: begin
            result.lamp_unlocked = 1'b1;
            result.lamp_collect  = 1'b1;
            mode_next            = vend_pkg::MODE_LOCK;
         end
         vend_pkg::MODE_LOCK: begin
            result.door_motor  = 1'b1;
            result.lamp_locked = 1'b1;
            mode_next          = vend_pkg::MODE_IDLE;
         end
         vend_pkg::MODE_QUIT: begin
            result.change_motor = 1'b1;
            result.lamp_locked  = 1'b1;
            result.lamp_change  = 1'b1;
            change_next         = '0;
            mode_next           = vend_pkg::MODE_IDLE;
         end
         default: begin
            mode_next = vend_pkg::MODE_IDLE;
         end
      endcase
      // The money fields show the low bits of the updated totals.
      credit_out        = CMP_W'(credit_next);
      change_out        = CMP_W'(change_next);
      result.next_mode  = vend_pkg::mode_code(mode_next);
      result.credit_now = credit_out[OUT_W-1:0];
      result.change_now = change_out[OUT_W-1:0];
   end

endmodule

// ===== design/vending_controller_fsm_unit.sv =====
// Vending machine controller. Each accepted request word is one pass of the
// control loop: five sampled button levels (half coin, whole coin, two item
// selects, cancel). The unit answers every request word with exactly one
// response word holding the motor and lamp levels of the mode that ran in
// that pass, the mode it moved to, and the credit and change due afterwards,
// all money in half-coin units. A request word is taken in every cycle in which
// the request side is ready: the mode, credit and change registers and the
// single output register all load on the accepting edge, so the rate is one
// word per clock unless the output register is stalled. The request side stays
// ready while the output register is empty or is being drained in the same
// cycle. Item prices are written through the csr port (index 0 is item one,
// index 1 is item two) and should only be changed while the unit is idle.
module vending_controller_fsm_unit #(
   parameter int MONEY_WIDTH = vend_pkg::MONEY_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  vend_pkg::vend_in_type                req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output vend_pkg::vend_out_type               rsp_data,
   input  logic                                 csr_we,
   input  logic [vend_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [vend_pkg::DATA_W-1:0]          csr_wdata
);

   // Machine state.
   vend_pkg::mode_type              mode_ff;
   vend_pkg::mode_type              mode_in;
   logic [MONEY_WIDTH-1:0]          credit_ff;
   logic [MONEY_WIDTH-1:0]          credit_in;
   logic [MONEY_WIDTH-1:0]          change_ff;
   logic [MONEY_WIDTH-1:0]          change_in;

   // Price registers.
   logic [vend_pkg::DATA_W-1:0]     price1_ff;
   logic [vend_pkg::DATA_W-1:0]     price2_ff;

   // Output register.
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   vend_pkg::vend_out_type          rsp_data_ff;
   vend_pkg::vend_out_type          step_result;

   logic                            accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   vend_step #(
      .MONEY_WIDTH(MONEY_WIDTH)
   ) u_step (
      .mode        (mode_ff),
      .credit      (credit_ff),
      .change_due  (change_ff),
      .price_first (price1_ff),
      .price_second(price2_ff),
      .buttons     (req_data),
      .mode_next   (mode_in),
      .credit_next (credit_in),
      .change_next (change_in),
      .result      (step_result)
   );

   // The response register refills on an accept and otherwise empties when
   // the downstream side takes its word.
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= vend_pkg::MODE_IDLE;
         credit_ff    <= '0;
         change_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            mode_ff   <= mode_in;
            credit_ff <= credit_in;
            change_ff <= change_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         price1_ff <= vend_pkg::PRICE_FIRST_RESET;
         price2_ff <= vend_pkg::PRICE_SECOND_RESET;
      end else if (csr_we) begin
         case (csr_index)
            vend_pkg::CSR_PRICE_FIRST:  price1_ff <= csr_wdata;
            vend_pkg::CSR_PRICE_SECOND: price2_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Payload register needs no reset; it is qualified by rsp_valid_ff.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
